>>> src/lbot_pkg.sv
// Package for the LED blob order tracker: types, sizes, register codes and states.
package lbot_pkg;

    // Fixed sizes of the block
    localparam int BLOB_COUNT = 5;
    localparam int IDX_W      = $clog2(BLOB_COUNT);
    localparam int COORD_W    = 16;
    localparam int SLOT_W     = 3;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int LIMIT_W    = SQ_W + 1;
    localparam int FRAC_BITS  = 6;

    // Register port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_MARGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_MARGIN = 3'd4;

    // Reset values in whole pixels (squared pixels for the match limit), scaled by the fraction bits at reset
    localparam int MATCH_LIMIT_PIX = 100;
    localparam int LEFT_PIX        = 10;
    localparam int RIGHT_PIX       = 630;
    localparam int TOP_PIX         = 10;
    localparam int BOTTOM_PIX      = 470;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOB_COUNT - 1);

    typedef logic [IDX_W-1:0] idx_t;

    // Input item: one centroid
    typedef struct packed {
        logic [COORD_W-1:0] blob_x;
        logic [COORD_W-1:0] blob_y;
    } blob_in_t;

    // Result item
    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [SLOT_W-1:0]  slot;
        logic               out_of_frame;
        logic               last;
    } blob_out_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EXT,
        ST_MID,
        ST_COPY,
        ST_MSQX,
        ST_MSQY,
        ST_PREP,
        ST_EMIT
    } state_t;

endpackage

>>> src/led_blob_order_tracker.sv
// Top level of the LED blob order tracker: loader, shared distance unit and sequencer.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    blob_in_t  (blob_x, blob_y)
//  m_        out        m_valid / m_ready    blob_out_t (out_x, out_y, slot, out_of_frame, last)
//  cfg_      in         cfg_wr_en            cfg_index, cfg_data
//
// Centroids are taken one per cycle while s_ready is high. The fifth of a frame starts a walk:
// a margin check of each blob, then on the first frame the extreme, interior and copy passes,
// or on later frames a pass in which the one 16x16 squarer handles dx^2 and dy^2 of each of
// the 25 pairs (a frame with a blob outside the margins skips these passes); a setup state
// follows, then the results (5, or 1 for a dropped frame), one per cycle that m_ready allows.
// s_ready is low from the fifth centroid until the last result is taken. Reset (aresetn,
// synchronous) restores the state, first-frame flag, configuration registers and load count.
module led_blob_order_tracker
    #(
        parameter int FRAC_BITS = lbot_pkg::FRAC_BITS
    )
    (
        input  logic                                aclk,
        input  logic                                aresetn,
        input  logic                                s_valid,
        output logic                                s_ready,
        input  lbot_pkg::blob_in_t                  s_data,
        output logic                                m_valid,
        input  logic                                m_ready,
        output lbot_pkg::blob_out_t                 m_data,
        input  logic                                cfg_wr_en,
        input  logic [lbot_pkg::CFG_IDX_W-1:0]      cfg_index,
        input  logic [lbot_pkg::CFG_DATA_W-1:0]     cfg_data
    );

    import lbot_pkg::*;

    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(MATCH_LIMIT_PIX) << (2 * FRAC_BITS);
    localparam logic [COORD_W-1:0] LEFT_RST   = COORD_W'(LEFT_PIX) << FRAC_BITS;
    localparam logic [COORD_W-1:0] RIGHT_RST  = COORD_W'(RIGHT_PIX) << FRAC_BITS;
    localparam logic [COORD_W-1:0] TOP_RST    = COORD_W'(TOP_PIX) << FRAC_BITS;
    localparam logic [COORD_W-1:0] BOTTOM_RST = COORD_W'(BOTTOM_PIX) << FRAC_BITS;

    state_t state_reg, state_next;

    // Configuration
    logic [LIMIT_W-1:0] limit_reg;
    logic [COORD_W-1:0] left_reg, right_reg, top_reg, bottom_reg;

    // Control
    idx_t load_reg;
    logic first_reg;
    logic drop_reg;
    idx_t i_reg, j_reg, k_reg;

    // Data stores
    blob_in_t frame_reg [BLOB_COUNT];
    blob_in_t rx_reg    [BLOB_COUNT];
    blob_in_t prev_reg  [BLOB_COUNT];

    // First frame extremes
    logic [COORD_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    idx_t ixmin_reg, ixmax_reg, iymin_reg, iymax_reg, imid_reg;

    // Matching
    logic [SQ_W-1:0]    sq_reg;
    logic [LIMIT_W-1:0] best_reg;
    idx_t               target_reg;

    blob_out_t out_reg;

    // Read ports
    idx_t     copy_idx, frame_rd, rx_rd, wr_slot;
    blob_in_t fsel, psel, rsel;

    logic               s_fire, m_fire, outs, inner, hit;
    logic [COORD_W-1:0] dx, dy, mul_a;
    logic [SQ_W-1:0]    mul;
    logic [LIMIT_W-1:0] d_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_data  = out_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    // Frame store read: source index on copy pass, walk index otherwise
    always_comb begin
        case (k_reg)
            3'd0:    copy_idx = iymax_reg;
            3'd1:    copy_idx = iymin_reg;
            3'd2:    copy_idx = ixmax_reg;
            3'd3:    copy_idx = ixmin_reg;
            default: copy_idx = imid_reg;
        endcase
    end

    assign frame_rd = (state_reg == ST_COPY) ? copy_idx : i_reg;
    assign fsel     = frame_reg[frame_rd];
    assign psel     = prev_reg[j_reg];
    assign rx_rd    = (state_reg == ST_EMIT && k_reg != LAST_IDX) ? k_reg + 1'b1 : '0;
    assign rsel     = rx_reg[rx_rd];

    // Margin test and strict interior test on the current blob
    assign outs  = (fsel.blob_x < left_reg) || (fsel.blob_x > right_reg) ||
                   (fsel.blob_y < top_reg)  || (fsel.blob_y > bottom_reg);
    assign inner = (fsel.blob_x > xmin_reg) && (fsel.blob_x < xmax_reg) &&
                   (fsel.blob_y > ymin_reg) && (fsel.blob_y < ymax_reg);

    // Shared squarer: dx in the ST_MSQX state of a pair, dy in the ST_MSQY state
    assign dx    = (fsel.blob_x > psel.blob_x) ? fsel.blob_x - psel.blob_x
                                               : psel.blob_x - fsel.blob_x;
    assign dy    = (fsel.blob_y > psel.blob_y) ? fsel.blob_y - psel.blob_y
                                               : psel.blob_y - fsel.blob_y;
    assign mul_a = (state_reg == ST_MSQX) ? dx : dy;
    assign mul   = mul_a * mul_a;
    assign d_sum = {1'b0, sq_reg} + {1'b0, mul};
    assign hit   = d_sum < best_reg;
    assign wr_slot = hit ? j_reg : target_reg;

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && load_reg == LAST_IDX) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_reg == LAST_IDX) begin
                    if (drop_reg || outs) state_next = ST_PREP;
                    else if (first_reg)   state_next = ST_EXT;
                    else                  state_next = ST_MSQX;
                end
            end
            ST_EXT: begin
                if (i_reg == LAST_IDX) state_next = ST_MID;
            end
            ST_MID: begin
                if (i_reg == LAST_IDX) state_next = ST_COPY;
            end
            ST_COPY: begin
                if (k_reg == LAST_IDX) state_next = ST_PREP;
            end
            ST_MSQX: begin
                state_next = ST_MSQY;
            end
            ST_MSQY: begin
                if (j_reg == LAST_IDX && i_reg == LAST_IDX) state_next = ST_PREP;
                else                                        state_next = ST_MSQX;
            end
            ST_PREP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_fire && out_reg.last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            load_reg   <= '0;
            first_reg  <= 1'b1;
            limit_reg  <= LIMIT_RST;
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
            top_reg    <= TOP_RST;
            bottom_reg <= BOTTOM_RST;
        end else begin
            state_reg <= state_next;

            // Register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MATCH_LIMIT:   limit_reg  <= cfg_data;
                    CFG_LEFT_MARGIN:   left_reg   <= cfg_data[COORD_W-1:0];
                    CFG_RIGHT_MARGIN:  right_reg  <= cfg_data[COORD_W-1:0];
                    CFG_TOP_MARGIN:    top_reg    <= cfg_data[COORD_W-1:0];
                    CFG_BOTTOM_MARGIN: bottom_reg <= cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end

            // Load count wraps at the end of a frame
            if (s_fire) begin
                load_reg <= (load_reg == LAST_IDX) ? '0 : load_reg + 1'b1;
            end

            // Accepted frame leaves the geometric ordering behind
            if (state_reg == ST_EMIT && m_fire && out_reg.last && !out_reg.out_of_frame) begin
                first_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    frame_reg[load_reg] <= s_data;
                    i_reg    <= '0;
                    drop_reg <= 1'b0;
                end
            end
            ST_CHECK: begin
                drop_reg <= drop_reg | outs;
                if (i_reg == LAST_IDX) begin
                    i_reg      <= '0;
                    j_reg      <= '0;
                    k_reg      <= '0;
                    best_reg   <= limit_reg;
                    target_reg <= '0;
                    for (int n = 0; n < BLOB_COUNT; n++) rx_reg[n] <= '0;
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            ST_EXT: begin
                // Running extremes, first strict one wins
                if (i_reg == '0) begin
                    xmin_reg  <= fsel.blob_x;
                    xmax_reg  <= fsel.blob_x;
                    ymin_reg  <= fsel.blob_y;
                    ymax_reg  <= fsel.blob_y;
                    ixmin_reg <= '0;
                    ixmax_reg <= '0;
                    iymin_reg <= '0;
                    iymax_reg <= '0;
                end else begin
                    if (fsel.blob_x < xmin_reg) begin
                        xmin_reg  <= fsel.blob_x;
                        ixmin_reg <= i_reg;
                    end
                    if (fsel.blob_x > xmax_reg) begin
                        xmax_reg  <= fsel.blob_x;
                        ixmax_reg <= i_reg;
                    end
                    if (fsel.blob_y < ymin_reg) begin
                        ymin_reg  <= fsel.blob_y;
                        iymin_reg <= i_reg;
                    end
                    if (fsel.blob_y > ymax_reg) begin
                        ymax_reg  <= fsel.blob_y;
                        iymax_reg <= i_reg;
                    end
                end
                i_reg <= (i_reg == LAST_IDX) ? '0 : i_reg + 1'b1;
            end
            ST_MID: begin
                // Last strictly interior blob, blob 0 if none
                if (i_reg == '0)  imid_reg <= '0;
                else if (inner)   imid_reg <= i_reg;
                i_reg <= (i_reg == LAST_IDX) ? '0 : i_reg + 1'b1;
            end
            ST_COPY: begin
                rx_reg[k_reg] <= fsel;
                k_reg <= (k_reg == LAST_IDX) ? '0 : k_reg + 1'b1;
            end
            ST_MSQX: begin
                sq_reg <= mul;
            end
            ST_MSQY: begin
                if (j_reg == LAST_IDX) begin
                    // Later blobs overwrite earlier ones in the same slot
                    rx_reg[wr_slot] <= fsel;
                    best_reg   <= limit_reg;
                    target_reg <= '0;
                    j_reg      <= '0;
                    i_reg      <= (i_reg == LAST_IDX) ? '0 : i_reg + 1'b1;
                end else begin
                    if (hit) begin
                        best_reg   <= d_sum;
                        target_reg <= j_reg;
                    end
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_PREP: begin
                k_reg <= '0;
                if (drop_reg) begin
                    out_reg <= '{out_x: '0, out_y: '0, slot: '0, out_of_frame: 1'b1, last: 1'b1};
                end else begin
                    out_reg <= '{out_x: rx_reg[0].blob_x, out_y: rx_reg[0].blob_y,
                                 slot: '0, out_of_frame: 1'b0, last: 1'b0};
                end
            end
            ST_EMIT: begin
                if (m_fire) begin
                    if (out_reg.last) begin
                        if (!out_reg.out_of_frame) begin
                            for (int n = 0; n < BLOB_COUNT; n++) prev_reg[n] <= rx_reg[n];
                        end
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        out_reg <= '{out_x: rsel.blob_x, out_y: rsel.blob_y,
                                     slot: SLOT_W'(rx_rd), out_of_frame: 1'b0,
                                     last: (rx_rd == LAST_IDX)};
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
